FILE: sv/vrc_pkg.sv
// shared constants, rectangle type and the compare/merge functions for the
// vertical rectangle coalescer; no dependencies
package vrc_pkg;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned COORD_BITS  = 12;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned ENTRY_W     = 4 * COORD_BITS;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS:0]   t_wide;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_rect;

    // vertical adjacency, a shared side edge and equal width
    function automatic logic rect_touches(t_rect e, t_rect n);
        logic vert;
        logic side;
        logic same_w;
        t_wide e_w;
        t_wide n_w;
        // sums one bit wider so the last row never wraps
        vert = ({1'b0, e.bottom} + t_wide'(1) == {1'b0, n.top}) ||
               ({1'b0, e.top} == {1'b0, n.bottom} + t_wide'(1));
        side = (e.left == n.left) || (e.right == n.right);
        // signed widths fit exactly in one extra bit
        e_w = {1'b0, e.right} - {1'b0, e.left};
        n_w = {1'b0, n.right} - {1'b0, n.left};
        same_w = (e_w == n_w);
        return vert && side && same_w;
    endfunction

    function automatic t_rect rect_merge(t_rect e, t_rect n);
        t_rect m;
        m.left   = (e.left   < n.left)   ? e.left   : n.left;
        m.top    = (e.top    < n.top)    ? e.top    : n.top;
        m.right  = (e.right  > n.right)  ? e.right  : n.right;
        m.bottom = (e.bottom > n.bottom) ? e.bottom : n.bottom;
        return m;
    endfunction

endpackage

FILE: sv/vrc_if.sv
// valid/ready channel interfaces for the coalescer's command input and
// rectangle output; depends on vrc_pkg for the coordinate type
interface vrc_in_if;
    logic            valid;
    logic            ready;
    logic            command;
    vrc_pkg::t_coord rect_left;
    vrc_pkg::t_coord rect_top;
    vrc_pkg::t_coord rect_right;
    vrc_pkg::t_coord rect_bottom;

    modport source (
        output valid, command, rect_left, rect_top, rect_right, rect_bottom,
        input  ready
    );
    modport sink (
        input  valid, command, rect_left, rect_top, rect_right, rect_bottom,
        output ready
    );
endinterface

interface vrc_out_if;
    logic            valid;
    logic            ready;
    vrc_pkg::t_coord out_left;
    vrc_pkg::t_coord out_top;
    vrc_pkg::t_coord out_right;
    vrc_pkg::t_coord out_bottom;
    logic            is_empty;
    logic            overflowed;
    logic            last_item;

    modport source (
        output valid, out_left, out_top, out_right, out_bottom,
               is_empty, overflowed, last_item,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_top, out_right, out_bottom,
               is_empty, overflowed, last_item,
        output ready
    );
endinterface

FILE: sv/vrc_ram.sv
// simple dual-port ram, one write and one registered read per cycle
// no package dependencies
module vrc_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 48,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/vertical_rect_coalescer.sv
// rectangle table in one ram, scanned one entry per cycle through its read port.
// add: on an empty table the entry is written at accept, otherwise accept plus
// a read-compare-write step for each stored entry; adds give no result.
// flush: first result registered in S_READ, then one per cycle while the sink
// takes them; an empty table gives one result. output register frees the input.
// reset (synchronous, active low) clears entry count, overflow flag, sequencer
// and output valid; ram contents are left as they are, no clearing pass
module vertical_rect_coalescer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vrc_in_if.sink      i_in,
    vrc_out_if.source   o_out
);
    import vrc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EMPTY = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_drop, n_drop;
    logic             r_merged, n_merged;
    t_rect            r_new, n_new;

    logic             r_out_valid, n_out_valid;
    t_rect            r_out, n_out;
    logic             r_out_empty, n_out_empty;
    logic             r_out_ovf, n_out_ovf;
    logic             r_out_last, n_out_last;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_rect            wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_raw;
    t_rect            rd_rect;

    logic             in_fire;
    logic             at_last;
    logic             hit;
    logic             slot_free;
    t_rect            in_rect;

    vrc_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    assign rd_rect   = t_rect'(rd_raw);
    assign in_fire   = i_in.valid && (r_state == S_IDLE);
    assign at_last   = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign hit       = rect_touches(rd_rect, r_new);
    assign slot_free = !r_out_valid || o_out.ready;

    assign in_rect.left   = i_in.rect_left;
    assign in_rect.top    = i_in.rect_top;
    assign in_rect.right  = i_in.rect_right;
    assign in_rect.bottom = i_in.rect_bottom;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_drop      = r_drop;
        n_merged    = r_merged;
        n_new       = r_new;
        n_out       = r_out;
        n_out_empty = r_out_empty;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !o_out.ready;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = rect_merge(rd_rect, r_new);
        rd_en       = 1'b0;
        rd_addr     = r_idx + IDX_W'(1);

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_idx    = '0;
                    n_merged = 1'b0;
                    n_new    = in_rect;
                    if (i_in.command == CMD_ADD) begin
                        if (r_count == '0) begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = in_rect;
                            n_count = CNT_W'(1);
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_state = S_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_SCAN: begin
                // entry r_idx is on the read port this cycle
                if (hit) begin
                    wr_en = 1'b1;
                end
                if (at_last) begin
                    n_state = S_IDLE;
                    if (!hit && !r_merged) begin
                        if (r_count < CNT_W'(TABLE_DEPTH)) begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[IDX_W-1:0];
                            wr_data = r_new;
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                end else begin
                    rd_en    = 1'b1;
                    n_idx    = r_idx + IDX_W'(1);
                    n_merged = r_merged || hit;
                end
            end
            S_READ: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = rd_rect;
                    n_out_empty = 1'b0;
                    n_out_ovf   = r_drop;
                    n_out_last  = at_last;
                    if (at_last) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_EMPTY: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out_empty = 1'b1;
                    n_out_ovf   = r_drop;
                    n_out_last  = 1'b1;
                    n_drop      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_merged    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_merged    <= n_merged;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new       <= n_new;
        r_out       <= n_out;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.out_left   = r_out.left;
    assign o_out.out_top    = r_out.top;
    assign o_out.out_right  = r_out.right;
    assign o_out.out_bottom = r_out.bottom;
    assign o_out.is_empty   = r_out_empty;
    assign o_out.overflowed = r_out_ovf;
    assign o_out.last_item  = r_out_last;

endmodule
